### sv/hlcm_pkg.sv
// shared constants, state encoding and controller/datapath handshake types
package hlcm_pkg;

    localparam int PERIOD_W        = 31;
    localparam int OUT_W           = 31;
    localparam int VALUE_WIDTH_DEF = 31;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_DIV  = 5'b00100,
        S_MUL  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic mul_init;
        logic mul_step;
        logic mul_commit;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic need_calc;
        logic gcd_done;
        logic div_done;
        logic mul_done;
        logic out_free;
        logic last;
    } t_status;

endpackage

### sv/hlcm_if.sv
// request channels: task period in, hyperperiod out
interface hlcm_in_if;
    import hlcm_pkg::*;

    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] period;
    logic                last_task;

    modport source (output valid, output period, output last_task, input ready);
    modport sink   (input valid, input period, input last_task, output ready);
endinterface

interface hlcm_out_if;
    import hlcm_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] set_lcm;
    logic             overflowed;

    modport source (output valid, output set_lcm, output overflowed, input ready);
    modport sink   (input valid, input set_lcm, input overflowed, output ready);
endinterface

### sv/hlcm_ctrl.sv
// sequencing state machine: load, gcd, divide, multiply, emit
module hlcm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hlcm_pkg::t_status i_st,
    output hlcm_pkg::t_cmd    o_cmd
);
    import hlcm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_st.in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_st.need_calc) begin
                        n_state = S_GCD;
                    end else if (i_st.in_last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_GCD: begin
                if (i_st.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_st.div_done) begin
                    o_cmd.mul_init = 1'b1;
                    n_state        = S_MUL;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_MUL: begin
                if (i_st.mul_done) begin
                    o_cmd.mul_commit = 1'b1;
                    n_state          = i_st.last ? S_FIN : S_IDLE;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_FIN: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/hlcm_datapath.sv
// running lcm registers, binary gcd, restoring divider, serial multiplier, output register
module hlcm_datapath #(
    parameter int VALUE_WIDTH = hlcm_pkg::VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hlcm_pkg::t_cmd    i_cmd,
    output hlcm_pkg::t_status o_st,
    hlcm_in_if.sink           i_in,
    hlcm_out_if.source        o_out
);
    import hlcm_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int KW = $clog2(W);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]     r_run;
    logic             r_ovf;
    logic [W-1:0]     r_p;
    logic             r_last;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [KW-1:0]    r_k;
    logic [W-1:0]     r_q;
    logic [W-1:0]     r_rem;
    logic [CW-1:0]    r_cnt;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_m;
    logic             r_mo;
    logic             r_pov;
    logic [OUT_W-1:0] r_hp;
    logic             r_out_ovf;
    logic             r_out_valid;

    logic [W-1:0]     w_pc;
    logic             w_pclamp;
    logic [OUT_W-1:0] w_hp;
    logic             w_hp_clamp;
    logic [W-1:0]     w_g;
    logic             w_a_ge;
    logic [W-1:0]     w_diff_ab;
    logic [W-1:0]     w_diff_ba;
    logic [W:0]       w_rem_sh;
    logic [W:0]       w_rem_sub;
    logic             w_qbit;
    logic [W:0]       w_sum;

    // period clamp into the value range
    if (W < PERIOD_W) begin : g_narrow_in
        assign w_pclamp = |i_in.period[PERIOD_W-1:W];
        assign w_pc     = w_pclamp ? '1 : i_in.period[W-1:0];
    end else begin : g_wide_in
        assign w_pclamp = 1'b0;
        assign w_pc     = W'(i_in.period);
    end

    // result clamp into the output field
    if (W > OUT_W) begin : g_wide_out
        assign w_hp_clamp = |r_run[W-1:OUT_W];
        assign w_hp       = w_hp_clamp ? '1 : r_run[OUT_W-1:0];
    end else begin : g_narrow_out
        assign w_hp_clamp = 1'b0;
        assign w_hp       = OUT_W'(r_run);
    end

    assign w_a_ge    = (r_a >= r_b);
    assign w_diff_ab = r_a - r_b;
    assign w_diff_ba = r_b - r_a;
    assign w_g       = (r_a | r_b) << r_k;

    // remainder stays below the divisor, so the borrow is the top bit
    assign w_rem_sh  = {r_rem, r_q[W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_b};
    assign w_qbit    = ~w_rem_sub[W];

    assign w_sum = {1'b0, r_acc} + {1'b0, r_m};

    assign i_in.ready         = i_cmd.in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.set_lcm      = r_hp;
    assign o_out.overflowed   = r_out_ovf;

    always_comb begin
        o_st           = '0;
        o_st.in_valid  = i_in.valid;
        o_st.in_last   = i_in.last_task;
        o_st.need_calc = (r_run != '0) && (w_pc != '0);
        o_st.gcd_done  = (r_a == '0) || (r_b == '0);
        o_st.div_done  = (r_cnt == '0);
        o_st.mul_done  = (r_q == '0) || r_pov;
        o_st.out_free  = !r_out_valid || o_out.ready;
        o_st.last      = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ovf <= r_ovf | w_pclamp;
                if (r_run == '0) begin
                    r_run <= w_pc;
                end else if (w_pc == '0) begin
                    r_run <= '0;
                end
            end else if (i_cmd.mul_commit) begin
                if (r_pov) begin
                    r_run <= '1;
                    r_ovf <= 1'b1;
                end else begin
                    r_run <= r_acc;
                end
            end else if (i_cmd.emit) begin
                r_run <= '0;
                r_ovf <= 1'b0;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p    <= w_pc;
            r_last <= i_in.last_task;
            r_a    <= r_run;
            r_b    <= w_pc;
            r_k    <= '0;
        end else if (i_cmd.gcd_step) begin
            priority if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (w_a_ge) begin
                r_a <= w_diff_ab >> 1;
            end else begin
                r_b <= w_diff_ba >> 1;
            end
        end else if (i_cmd.div_init) begin
            r_b   <= w_g;
            r_q   <= r_run;
            r_rem <= '0;
            r_cnt <= CW'(W);
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? w_rem_sub[W-1:0] : w_rem_sh[W-1:0];
            r_q   <= {r_q[W-2:0], w_qbit};
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.mul_init) begin
            r_m   <= r_p;
            r_mo  <= 1'b0;
            r_acc <= '0;
            r_pov <= 1'b0;
        end else if (i_cmd.mul_step) begin
            // r_mo marks a multiplicand already past the value range
            if (r_q[0]) begin
                if (r_mo || w_sum[W]) begin
                    r_pov <= 1'b1;
                end else begin
                    r_acc <= w_sum[W-1:0];
                end
            end
            r_q  <= r_q >> 1;
            r_mo <= r_mo | r_m[W-1];
            r_m  <= r_m << 1;
        end

        if (i_cmd.emit) begin
            r_hp      <= w_hp;
            r_out_ovf <= r_ovf | w_hp_clamp;
        end
    end

    a_gcd_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.gcd_step |-> (r_a != '0 && r_b != '0))
        else $error("gcd step with a zero operand");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_b != '0))
        else $error("divide by zero gcd");

    a_gcd_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_init |-> (r_rem == '0))
        else $error("gcd does not divide running value");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_run == '0 && !r_ovf && r_out_valid))
        else $error("state not cleared after result");

endmodule

### sv/hyperperiod_lcm_accumulator_core.sv
// Hyperperiod accumulator: running lcm of task periods with saturation.
//
// Input channel i_in carries one task period and a last_task marker per
// request; output channel o_out carries the hyperperiod of the set and a
// sticky overflow flag, one request for each input marked last_task.
// The first period of a set, a period arriving on a zero running value,
// and a zero period are absorbed on load. Any other period runs a binary
// gcd (one subtract/shift per step), a restoring divide of the running
// value by the gcd and a shift-add multiply with saturation check; a
// last request then passes through a finish state that loads the output
// register. One period is in work at a time; i_in.ready is high only
// while the sequencer is idle.
// The result sits in an output register, so the next set is taken while a
// result waits; a new result that finds the register still full waits
// there and holds off further input until o_out.ready.
// Synchronous active-low reset clears the running value, the overflow
// flag and the output valid.
module hyperperiod_lcm_accumulator_core #(
    parameter int VALUE_WIDTH = hlcm_pkg::VALUE_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hlcm_in_if.sink    i_in,
    hlcm_out_if.source o_out
);
    import hlcm_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;

    hlcm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    hlcm_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_st    (w_st),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
